[rtl/drum_voice_allocator_macros.svh]
// Assertion macros for the drum voice allocator RTL, included by dva_datapath.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef DRUM_VOICE_ALLOCATOR_MACROS_SVH
`define DRUM_VOICE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dva_pkg.sv]
// Package for the drum voice allocator: codes, control structs and gain tables.
// Depends on nothing; used by dva_ctrl, dva_datapath and drum_voice_allocator.
`default_nettype none

package dva_pkg;

    localparam int VOICES    = 8;
    localparam int VOICE_W   = 3;
    localparam int NOTE_LOW  = 27;
    localparam int NOTE_HIGH = 87;
    localparam int PAN_N     = NOTE_HIGH - NOTE_LOW + 1;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_FINISHED = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_CHOKE = 2'd1;
    localparam logic [1:0] ACT_FADE  = 2'd2;

    localparam logic [4:0] FADE_START = 5'd1;
    localparam logic [4:0] FADE_CHOKE = 5'd5;
    localparam logic [4:0] FADE_OUT   = 5'd20;

    localparam logic [6:0] HAT_CLOSED = 7'd42;
    localparam logic [6:0] HAT_PEDAL  = 7'd44;
    localparam logic [6:0] HAT_OPEN   = 7'd46;

    localparam logic [31:0] FADE_LEAD_MS = 32'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EMIT,
        S_FREE,
        S_GAIN,
        S_MUL,
        S_START
    } state_t;

    typedef struct packed {
        logic latch;
        logic scan_clear;
        logic scan_mask;
        logic emit_one;
        logic release_voice;
        logic scan_free;
        logic gain_lookup;
        logic gain_mul;
        logic start;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       note_ok;
        logic       hihat;
        logic       scan_last;
        logic       mask_empty;
        logic       out_free;
    } sts_t;

    localparam int PAN_TENTHS [PAN_N] = '{
        0, -2, -3, 3, -7, 0, 0, 0, 0, 0,
        -4, -1, 0, 0, -5, 3, -3, 3, -5, 4,
        -3, -1, -8, 2, 6, -9, 7, 5, -7, 1,
        8, 6, 6, -6, -8, 7, 5, 3, -5, -7,
        8, 6, -4, 4, 7, 9, -6, -8, 0, 5,
        3, -7, -9, 6, 8, -5, 7, 9, -8, -4,
        -6
    };

    function automatic logic is_hihat(input logic [6:0] n);
        return (n == HAT_CLOSED) || (n == HAT_PEDAL) || (n == HAT_OPEN);
    endfunction

    function automatic logic [63:0] log2_q30(input logic [31:0] v);
        int unsigned n;
        logic [63:0] x;
        logic [63:0] r;
        n = 0;
        while (n < 31 && (v >> (n + 1)) != 0) n++;
        x = ({32'd0, v} << 30) >> n;
        r = 64'(n) << 30;
        for (int i = 29; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    localparam logic [63:0] LOG2_127 = log2_q30(32'd127);

    function automatic logic [127:0][15:0] build_vel_curve();
        logic [127:0][15:0] tab;
        logic [63:0] r;
        tab[0] = 16'd0;
        for (int v = 1; v < 128; v++) begin
            r = (log2_q30(32'(v)) << 30) / LOG2_127;
            tab[v] = 16'((r * r + (64'd1 << 44)) >> 45);
        end
        return tab;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] res;
        logic [63:0] bitv;
        y = y_in;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > y) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (y >= res + bitv) begin
                y = y - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] pan_boost(input logic [63:0] u, input logic [63:0] b);
        logic [63:0] x;
        logic [63:0] g;
        x = (64'd1 << 28) * b * b * u;
        g = isqrt64(x / 64'd200000);
        if ((2 * g + 1) * (2 * g + 1) * 64'd200000 <= 4 * x) g = g + 1;
        return g;
    endfunction

    function automatic logic [PAN_N-1:0][14:0] build_pan(input logic right);
        logic [PAN_N-1:0][14:0] tab;
        int t;
        int at;
        for (int i = 0; i < PAN_N; i++) begin
            t = PAN_TENTHS[i];
            at = (t < 0) ? -t : t;
            tab[i] = 15'(pan_boost(64'(right ? 10 + t : 10 - t), 64'(140 - 4 * at)));
        end
        return tab;
    endfunction

    localparam logic [127:0][15:0]      VEL_CURVE = build_vel_curve();
    localparam logic [PAN_N-1:0][14:0]  PAN_LEFT  = build_pan(1'b0);
    localparam logic [PAN_N-1:0][14:0]  PAN_RIGHT = build_pan(1'b1);

endpackage

`default_nettype wire

[rtl/dva_ctrl.sv]
// Controller state machine of the drum voice allocator.
// Depends on dva_pkg; drives dva_datapath through cmd_t and reads sts_t.
`default_nettype none

module dva_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dva_pkg::sts_t sts,
    output dva_pkg::cmd_t      cmd
);

    dva_pkg::state_t state_reg;
    dva_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dva_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            dva_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = dva_pkg::S_DECODE;
                end
            end
            dva_pkg::S_DECODE:
            begin
                cmd.scan_clear = 1'b1;
                unique case (sts.kind)
                    dva_pkg::KIND_NOTE_ON:
                    begin
                        if (!sts.note_ok)
                            state_next = dva_pkg::S_IDLE;
                        else if (sts.hihat)
                            state_next = dva_pkg::S_SCAN;
                        else
                            state_next = dva_pkg::S_FREE;
                    end
                    dva_pkg::KIND_FINISHED:
                    begin
                        cmd.release_voice = 1'b1;
                        state_next = dva_pkg::S_IDLE;
                    end
                    dva_pkg::KIND_TICK:
                    begin
                        state_next = dva_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = dva_pkg::S_IDLE;
                    end
                endcase
            end
            dva_pkg::S_SCAN:
            begin
                cmd.scan_mask = 1'b1;
                if (sts.scan_last)
                    state_next = dva_pkg::S_EMIT;
            end
            dva_pkg::S_EMIT:
            begin
                if (sts.mask_empty)
                begin
                    cmd.scan_clear = 1'b1;
                    if (sts.kind == dva_pkg::KIND_TICK)
                        state_next = dva_pkg::S_IDLE;
                    else
                        state_next = dva_pkg::S_FREE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_one = 1'b1;
                end
            end
            dva_pkg::S_FREE:
            begin
                cmd.scan_free = 1'b1;
                if (sts.scan_last)
                    state_next = dva_pkg::S_GAIN;
            end
            dva_pkg::S_GAIN:
            begin
                cmd.gain_lookup = 1'b1;
                state_next = dva_pkg::S_MUL;
            end
            dva_pkg::S_MUL:
            begin
                cmd.gain_mul = 1'b1;
                state_next = dva_pkg::S_START;
            end
            dva_pkg::S_START:
            begin
                if (sts.out_free)
                begin
                    cmd.start = 1'b1;
                    state_next = dva_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dva_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/dva_datapath.sv]
// Datapath of the drum voice allocator: voice state, scans, gain lookup and result register.
// Depends on dva_pkg and drum_voice_allocator_macros.svh; driven by dva_ctrl.
`default_nettype none
`include "drum_voice_allocator_macros.svh"

module dva_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic [1:0]    kind,
    input  wire logic [6:0]    note,
    input  wire logic [6:0]    velocity,
    input  wire logic [31:0]   now_ms,
    input  wire logic [2:0]    voice_index,
    input  wire logic [31:0]   sample_length_ms,
    input  wire dva_pkg::cmd_t cmd,
    output dva_pkg::sts_t      sts,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         action,
    output logic [2:0]         voice,
    output logic [14:0]        left_gain,
    output logic [14:0]        right_gain,
    output logic [4:0]         fade_ms,
    output logic               stolen,
    output logic [31:0]        dropped_count,
    output logic               last
);

    logic enable_reg;

    logic [1:0]  kind_reg;
    logic [6:0]  note_reg;
    logic [6:0]  velocity_reg;
    logic [31:0] now_reg;
    logic [2:0]  vidx_reg;
    logic [31:0] len_reg;

    logic [dva_pkg::VOICES-1:0] busy_reg;
    logic [dva_pkg::VOICES-1:0] pending_reg;
    logic [6:0]  vnote_reg  [dva_pkg::VOICES];
    logic [31:0] vstart_reg [dva_pkg::VOICES];
    logic [31:0] vdue_reg   [dva_pkg::VOICES];
    logic [31:0] steal_count_reg;

    logic [dva_pkg::VOICE_W-1:0] idx_reg;
    logic [dva_pkg::VOICES-1:0]  mask_reg;
    logic                        found_reg;
    logic [dva_pkg::VOICE_W-1:0] sel_reg;
    logic [31:0]                 best_reg;

    logic [15:0] vc_reg;
    logic [14:0] pl_reg;
    logic [14:0] pr_reg;
    logic [31:0] due_reg;
    logic [14:0] lg_reg;
    logic [14:0] rg_reg;

    logic        out_valid_reg;
    logic [1:0]  action_reg;
    logic [2:0]  voice_reg;
    logic [14:0] left_reg;
    logic [14:0] right_reg;
    logic [4:0]  fade_reg;
    logic        stolen_reg;
    logic [31:0] dropped_reg;
    logic        last_reg;

    logic                        out_free;
    logic [dva_pkg::VOICE_W-1:0] low_pos;
    logic                        mask_single;
    logic                        mask_bit;
    logic [5:0]                  pan_idx;
    logic [31:0]                 prod_l;
    logic [31:0]                 prod_r;
    logic                        is_tick;

    assign out_free = !out_valid_reg || out_ready;
    assign is_tick  = (kind_reg == dva_pkg::KIND_TICK);
    assign pan_idx  = 6'(note_reg - 7'(dva_pkg::NOTE_LOW));
    assign prod_l   = 32'(vc_reg) * 32'(pl_reg) + 32'h4000;
    assign prod_r   = 32'(vc_reg) * 32'(pr_reg) + 32'h4000;
    assign mask_single = (mask_reg & (mask_reg - 1'b1)) == '0;

    always_comb
    begin
        low_pos = '0;
        for (int i = dva_pkg::VOICES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                low_pos = dva_pkg::VOICE_W'(i);
        end
    end

    always_comb
    begin
        if (is_tick)
            mask_bit = busy_reg[idx_reg] && pending_reg[idx_reg] &&
                       (now_reg >= vdue_reg[idx_reg]);
        else
            mask_bit = busy_reg[idx_reg] && dva_pkg::is_hihat(vnote_reg[idx_reg]) &&
                       (vnote_reg[idx_reg] != note_reg);
    end

    always_comb
    begin
        sts.kind       = kind_reg;
        sts.note_ok    = enable_reg && (note_reg >= 7'(dva_pkg::NOTE_LOW)) &&
                         (note_reg <= 7'(dva_pkg::NOTE_HIGH));
        sts.hihat      = dva_pkg::is_hihat(note_reg);
        sts.scan_last  = (idx_reg == dva_pkg::VOICE_W'(dva_pkg::VOICES - 1));
        sts.mask_empty = (mask_reg == '0);
        sts.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg     <= kind;
            note_reg     <= note;
            velocity_reg <= velocity;
            now_reg      <= now_ms;
            vidx_reg     <= voice_index;
            len_reg      <= sample_length_ms;
        end
        if (cmd.scan_free)
        begin
            if (!found_reg)
            begin
                if (!busy_reg[idx_reg])
                begin
                    sel_reg <= idx_reg;
                end
                else if (idx_reg == '0 || vstart_reg[idx_reg] < best_reg)
                begin
                    sel_reg  <= idx_reg;
                    best_reg <= vstart_reg[idx_reg];
                end
            end
        end
        if (cmd.gain_lookup)
        begin
            vc_reg  <= dva_pkg::VEL_CURVE[velocity_reg];
            pl_reg  <= dva_pkg::PAN_LEFT[pan_idx];
            pr_reg  <= dva_pkg::PAN_RIGHT[pan_idx];
            due_reg <= now_reg + ((len_reg > dva_pkg::FADE_LEAD_MS) ?
                                  len_reg - dva_pkg::FADE_LEAD_MS : 32'd0);
        end
        if (cmd.gain_mul)
        begin
            lg_reg <= prod_l[29:15];
            rg_reg <= prod_r[29:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            mask_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clear)
            begin
                idx_reg   <= '0;
                mask_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_mask)
            begin
                mask_reg[idx_reg] <= mask_bit;
                idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.scan_free)
            begin
                if (!busy_reg[idx_reg])
                    found_reg <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.emit_one)
            begin
                mask_reg[low_pos] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= '0;
            pending_reg     <= '0;
            steal_count_reg <= '0;
            for (int i = 0; i < dva_pkg::VOICES; i++)
            begin
                vnote_reg[i]  <= '0;
                vstart_reg[i] <= '0;
                vdue_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.release_voice && (32'(vidx_reg) < dva_pkg::VOICES))
            begin
                busy_reg[vidx_reg]    <= 1'b0;
                pending_reg[vidx_reg] <= 1'b0;
            end
            if (cmd.emit_one)
            begin
                if (is_tick)
                    pending_reg[low_pos] <= 1'b0;
                else
                    busy_reg[low_pos] <= 1'b0;
            end
            if (cmd.start)
            begin
                busy_reg[sel_reg]    <= 1'b1;
                pending_reg[sel_reg] <= 1'b1;
                vnote_reg[sel_reg]   <= note_reg;
                vstart_reg[sel_reg]  <= now_reg;
                vdue_reg[sel_reg]    <= due_reg;
                if (!found_reg)
                    steal_count_reg <= steal_count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_one || cmd.start)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_one)
        begin
            action_reg  <= is_tick ? dva_pkg::ACT_FADE : dva_pkg::ACT_CHOKE;
            voice_reg   <= 3'(low_pos);
            left_reg    <= '0;
            right_reg   <= '0;
            fade_reg    <= is_tick ? dva_pkg::FADE_OUT : dva_pkg::FADE_CHOKE;
            stolen_reg  <= 1'b0;
            dropped_reg <= steal_count_reg;
            last_reg    <= is_tick && mask_single;
        end
        else if (cmd.start)
        begin
            action_reg  <= dva_pkg::ACT_START;
            voice_reg   <= 3'(sel_reg);
            left_reg    <= lg_reg;
            right_reg   <= rg_reg;
            fade_reg    <= dva_pkg::FADE_START;
            stolen_reg  <= !found_reg;
            dropped_reg <= found_reg ? steal_count_reg : steal_count_reg + 32'd1;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign voice         = voice_reg;
    assign left_gain     = left_reg;
    assign right_gain    = right_reg;
    assign fade_ms       = fade_reg;
    assign stolen        = stolen_reg;
    assign dropped_count = dropped_reg;
    assign last          = last_reg;

    `DVA_ASSERT_SAME(a_emit_has_work, cmd.emit_one, mask_reg != '0, "emit with empty mask")
    `DVA_ASSERT_SAME(a_result_slot_free, cmd.emit_one || cmd.start, out_free, "result overwritten")
    `DVA_ASSERT_NEXT(a_steal_counts, cmd.start && !found_reg,
        steal_count_reg == $past(steal_count_reg) + 32'd1, "steal count not bumped")

endmodule

`default_nettype wire

[rtl/drum_voice_allocator.sv]
// Drum voice allocator: the input channel takes note-on, finished and tick items;
// the output channel gives start, choke and fade-out items, the last marked by last.
// One register, enable, is written through cfg_we and cfg_wdata; reset sets it to 1.
// A hi-hat note-on first builds a choke list over the eight voices, sends one
// choke item per cycle while the output register is free, then scans for a free
// or oldest voice, looks up and multiplies the gains and sends the start item.
// One item is handled at a time; in_ready is high only between items.
// Results sit in an output register; a stalled receiver holds the block at the
// next result until out_ready is seen. Reset frees all voices, clears the
// steal count and empties the output register.
// Depends on dva_pkg, dva_ctrl and dva_datapath.
`default_nettype none

module drum_voice_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [6:0]  note,
    input  wire logic [6:0]  velocity,
    input  wire logic [31:0] now_ms,
    input  wire logic [2:0]  voice_index,
    input  wire logic [31:0] sample_length_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       action,
    output logic [2:0]       voice,
    output logic [14:0]      left_gain,
    output logic [14:0]      right_gain,
    output logic [4:0]       fade_ms,
    output logic             stolen,
    output logic [31:0]      dropped_count,
    output logic             last
);

    dva_pkg::cmd_t cmd;
    dva_pkg::sts_t sts;

    dva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dva_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .kind             (kind),
        .note             (note),
        .velocity         (velocity),
        .now_ms           (now_ms),
        .voice_index      (voice_index),
        .sample_length_ms (sample_length_ms),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .voice            (voice),
        .left_gain        (left_gain),
        .right_gain       (right_gain),
        .fade_ms          (fade_ms),
        .stolen           (stolen),
        .dropped_count    (dropped_count),
        .last             (last)
    );

endmodule

`default_nettype wire
